// File: rtl/core/voxel_space_carving_check_macros.svh
// assertion macros for the voxel space carving check
// expects clk and arst_n in the scope where a macro is used
`ifndef VOXEL_SPACE_CARVING_CHECK_MACROS_SVH
`define VOXEL_SPACE_CARVING_CHECK_MACROS_SVH

// same-cycle implication, off while in reset
`define VSCC_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vscc assertion failed");

// next-cycle implication, off while in reset
`define VSCC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vscc assertion failed");

`endif

// File: rtl/core/vscc_pkg.sv
// shared types, codes and constants of the voxel space carving check
// no dependencies
package vscc_pkg;

	// camera coordinate width (2^-46 resolution), projection numerator width, pixel bits
	localparam int PW = 66;
	localparam int NW = 104;
	localparam int QW = 11;

	localparam int POSE_SLOTS = 12;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 32;

	localparam int DEF_MAX_MASK_WIDTH = 1024;
	localparam int DEF_MAX_MASK_HEIGHT = 1024;

	localparam logic [1:0] MODE_POSE = 2'd0;
	localparam logic [1:0] MODE_MASK = 2'd1;
	localparam logic [1:0] MODE_VOXEL = 2'd2;

	localparam logic [1:0] LBL_UNSEEN = 2'd0;
	localparam logic [1:0] LBL_CARVED = 2'd1;
	localparam logic [1:0] LBL_SEEN = 2'd2;
	localparam logic [1:0] LBL_SPARE = 2'd3;

	localparam logic [2:0] REG_FOCAL_X = 3'd0;
	localparam logic [2:0] REG_FOCAL_Y = 3'd1;
	localparam logic [2:0] REG_PRINCIPAL_X = 3'd2;
	localparam logic [2:0] REG_PRINCIPAL_Y = 3'd3;
	localparam logic [2:0] REG_IMAGE_WIDTH = 3'd4;
	localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;

	localparam logic [30:0] FOCAL_RESET = 31'd65536;
	localparam logic [10:0] IMAGE_SIZE_RESET = 11'd1024;

	typedef enum logic [1:0] {
		KIND_POSE,
		KIND_MASK,
		KIND_VOXEL
	} kind_t;

	typedef enum logic [2:0] {
		OUT_ALREADY = 3'd0,
		OUT_BEHIND = 3'd1,
		OUT_OUTSIDE = 3'd2,
		OUT_CARVED = 3'd3,
		OUT_FIRST = 3'd4,
		OUT_AGAIN = 3'd5
	} outcome_t;

	typedef struct packed {
		kind_t kind;
		logic [3:0] idx;
		logic signed [31:0] value;
		logic [9:0] col;
		logic [9:0] row;
		logic pix_on;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [1:0] label;
	} qitem_t;

	typedef struct packed {
		logic [30:0] fx;
		logic [30:0] fy;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [10:0] width;
		logic [10:0] height;
	} cfg_t;

	typedef struct packed {
		logic vld;
		logic is_mask;
		logic pix_on;
		logic done;
		logic [1:0] label;
		outcome_t outcome;
	} ctl_t;

endpackage

// File: rtl/core/vscc_fifo.sv
// small register queue used between front and back and on the result side
// depends on nothing but its parameters
module vscc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic [WIDTH-1:0] din,
	output logic full,
	input logic pop,
	output logic [WIDTH-1:0] dout,
	output logic empty
);
	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTRW-1:0] wr_q;
	logic [PTRW-1:0] rd_q;
	logic [CNTW-1:0] cnt_q;
	logic push_ok;
	logic pop_ok;

	assign full = (cnt_q == CNTW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok = pop && !empty;
	assign dout = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= (wr_q == PTRW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_q <= (rd_q == PTRW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

// File: rtl/core/vscc_front.sv
// front part: accepts input words, drops the ones with no effect, normalizes labels
// depends on vscc_pkg
module vscc_front #(
	parameter int MAX_MASK_WIDTH = vscc_pkg::DEF_MAX_MASK_WIDTH,
	parameter int MAX_MASK_HEIGHT = vscc_pkg::DEF_MAX_MASK_HEIGHT
) (
	input logic push,
	output logic full,
	input logic [1:0] mode,
	input logic [3:0] coef_index,
	input logic signed [31:0] coef_value,
	input logic [9:0] pixel_col,
	input logic [9:0] pixel_row,
	input logic pixel_on,
	input logic signed [31:0] center_x,
	input logic signed [31:0] center_y,
	input logic signed [31:0] center_z,
	input logic [1:0] label_in,
	input logic q_full,
	output logic q_push,
	output vscc_pkg::qitem_t q_item
);
	import vscc_pkg::*;

	logic keep;
	kind_t kind;

	always_comb begin
		keep = 1'b0;
		kind = KIND_VOXEL;
		unique case (mode)
			MODE_POSE: begin
				kind = KIND_POSE;
				keep = (int'(coef_index) < POSE_SLOTS);
			end
			MODE_MASK: begin
				kind = KIND_MASK;
				keep = (int'(pixel_col) < MAX_MASK_WIDTH) && (int'(pixel_row) < MAX_MASK_HEIGHT);
			end
			MODE_VOXEL: begin
				kind = KIND_VOXEL;
				keep = 1'b1;
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	always_comb begin
		q_item.kind = kind;
		q_item.idx = coef_index;
		q_item.value = coef_value;
		q_item.col = pixel_col;
		q_item.row = pixel_row;
		q_item.pix_on = pixel_on;
		q_item.cx = center_x;
		q_item.cy = center_y;
		q_item.cz = center_z;
		// label three behaves as seen
		q_item.label = (label_in == LBL_SPARE) ? LBL_SEEN : label_in;
	end

	assign full = q_full;
	assign q_push = push && !q_full && keep;

endmodule

// File: rtl/core/vscc_back.sv
// back part: pose store, projection pipeline with pipelined divider, mask memory
// depends on vscc_pkg
module vscc_back #(
	parameter int MAX_MASK_WIDTH = vscc_pkg::DEF_MAX_MASK_WIDTH,
	parameter int MAX_MASK_HEIGHT = vscc_pkg::DEF_MAX_MASK_HEIGHT
) (
	input logic clk,
	input logic arst_n,
	input vscc_pkg::cfg_t cfg,
	input logic item_valid,
	input vscc_pkg::qitem_t item,
	output logic item_pop,
	input logic res_taken,
	output logic res_push,
	output logic [1:0] res_label,
	output vscc_pkg::outcome_t res_outcome
);
	import vscc_pkg::*;

	localparam int MASK_DEPTH = MAX_MASK_WIDTH * MAX_MASK_HEIGHT;
	localparam int MAW = (MASK_DEPTH > 1) ? $clog2(MASK_DEPTH) : 1;
	localparam int CW = $clog2(OUT_DEPTH + 1);

	function automatic logic [MAW-1:0] mask_addr(input logic [QW-1:0] r, input logic [QW-1:0] c);
		logic [31:0] a;
		a = 32'(r) * 32'(MAX_MASK_WIDTH) + 32'(c);
		return a[MAW-1:0];
	endfunction

	function automatic logic pos_nw(input logic signed [NW-1:0] v);
		return !v[NW-1] && (v != '0);
	endfunction

	// pose store and issue
	logic signed [31:0] pose_q [POSE_SLOTS];
	logic [CW-1:0] reserved_q;
	logic credit_ok;
	logic issue_voxel;
	logic signed [31:0] ctr [3];

	assign credit_ok = (reserved_q < CW'(OUT_DEPTH));
	assign item_pop = item_valid && ((item.kind != KIND_VOXEL) || credit_ok);
	assign issue_voxel = item_pop && (item.kind == KIND_VOXEL);
	assign ctr[0] = item.cx;
	assign ctr[1] = item.cy;
	assign ctr[2] = item.cz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POSE_SLOTS; i++) begin
				pose_q[i] <= '0;
			end
		end else if (item_pop && item.kind == KIND_POSE) begin
			pose_q[item.idx] <= item.value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= '0;
		end else if (issue_voxel && !res_taken) begin
			reserved_q <= reserved_q + 1'b1;
		end else if (res_taken && !issue_voxel) begin
			reserved_q <= reserved_q - 1'b1;
		end
	end

	// effective image limits
	logic [10:0] lim_x;
	logic [10:0] lim_y;
	assign lim_x = (int'(cfg.width) < MAX_MASK_WIDTH) ? cfg.width : 11'(MAX_MASK_WIDTH);
	assign lim_y = (int'(cfg.height) < MAX_MASK_HEIGHT) ? cfg.height : 11'(MAX_MASK_HEIGHT);

	// pipeline registers
	ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5, ctl_s6, ctl_sa, ctl_sm;
	ctl_t ctl_d [QW+1];
	logic [MAW-1:0] addr_s1, addr_s2, addr_s3, addr_s4, addr_s5, addr_s6, addr_sa;
	logic [MAW-1:0] addr_d [QW+1];

	logic signed [63:0] prod_s1 [9];
	logic signed [31:0] tr_s1 [3];
	logic signed [PW-1:0] sa_s2 [3];
	logic signed [PW-1:0] sb_s2 [3];
	logic signed [PW-1:0] p_s3 [3];

	logic signed [65:0] pfl_x_s4, pfl_y_s4, zcl_x_s4, zcl_y_s4;
	logic signed [64:0] pfh_x_s4, pfh_y_s4, zch_x_s4, zch_y_s4;
	logic signed [77:0] zl_x_s4, zl_y_s4;
	logic signed [PW-1:0] z_s4;

	logic signed [NW-1:0] pf_x_s5, pf_y_s5, zc_x_s5, zc_y_s5, den_s5, dlim_x_s5, dlim_y_s5;
	logic signed [NW-1:0] num_x_s6, num_y_s6, den_s6, dlim_x_s6, dlim_y_s6;

	logic signed [NW-1:0] rem_x_d [QW+1];
	logic signed [NW-1:0] rem_y_d [QW+1];
	logic signed [NW-1:0] den_d [QW+1];
	logic [QW-1:0] q_x_d [QW+1];
	logic [QW-1:0] q_y_d [QW+1];

	logic mask_bit_sm;
	logic mask_mem [MASK_DEPTH];

	// stage decisions
	logic pz_pos;
	logic signed [NW-1:0] sum_x, sum_y, dif_x, dif_y;
	logic in_image;
	ctl_t ctl_s1_nx, ctl_s4_nx, ctl_d0_nx;

	assign pz_pos = !p_s3[2][PW-1] && (p_s3[2] != '0);
	assign sum_x = num_x_s6 + den_s6;
	assign sum_y = num_y_s6 + den_s6;
	assign dif_x = dlim_x_s6 - num_x_s6;
	assign dif_y = dlim_y_s6 - num_y_s6;
	assign in_image = pos_nw(sum_x) && pos_nw(dif_x) && (lim_x != '0)
		&& pos_nw(sum_y) && pos_nw(dif_y) && (lim_y != '0);

	always_comb begin
		ctl_s1_nx.vld = item_pop && (item.kind != KIND_POSE);
		ctl_s1_nx.is_mask = (item.kind == KIND_MASK);
		ctl_s1_nx.pix_on = item.pix_on;
		ctl_s1_nx.done = (item.label == LBL_CARVED);
		ctl_s1_nx.label = item.label;
		ctl_s1_nx.outcome = OUT_ALREADY;
		ctl_s4_nx = ctl_s3;
		if (ctl_s3.vld && !ctl_s3.is_mask && !ctl_s3.done && !pz_pos) begin
			ctl_s4_nx.done = 1'b1;
			ctl_s4_nx.outcome = OUT_BEHIND;
		end
		ctl_d0_nx = ctl_s6;
		if (ctl_s6.vld && !ctl_s6.is_mask && !ctl_s6.done && !in_image) begin
			ctl_d0_nx.done = 1'b1;
			ctl_d0_nx.outcome = OUT_OUTSIDE;
		end
	end

	// control path
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_d[0] <= '0;
			ctl_sa <= '0;
			ctl_sm <= '0;
		end else begin
			ctl_s1 <= ctl_s1_nx;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s4_nx;
			ctl_s5 <= ctl_s4;
			ctl_s6 <= ctl_s5;
			ctl_d[0] <= ctl_d0_nx;
			ctl_sa <= ctl_d[QW];
			ctl_sm <= ctl_sa;
		end
	end

	// rotation, translation and projection terms
	always_ff @(posedge clk) begin
		addr_s1 <= mask_addr(QW'(item.row), QW'(item.col));
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 3; j++) begin
				prod_s1[3*k+j] <= pose_q[3*k+j] * ctr[j];
			end
			tr_s1[k] <= pose_q[9+k];
		end

		addr_s2 <= addr_s1;
		for (int k = 0; k < 3; k++) begin
			sa_s2[k] <= PW'(prod_s1[3*k]) + PW'(prod_s1[3*k+1]);
			sb_s2[k] <= PW'(prod_s1[3*k+2]) + {{(PW-62){tr_s1[k][31]}}, tr_s1[k], 30'b0};
		end

		addr_s3 <= addr_s2;
		for (int k = 0; k < 3; k++) begin
			p_s3[k] <= sa_s2[k] + sb_s2[k];
		end

		// split each coordinate into an unsigned low part and a signed high part
		addr_s4 <= addr_s3;
		pfl_x_s4 <= $signed({1'b0, p_s3[0][32:0]}) * $signed({1'b0, cfg.fx});
		pfh_x_s4 <= $signed(p_s3[0][PW-1:33]) * $signed({1'b0, cfg.fx});
		pfl_y_s4 <= $signed({1'b0, p_s3[1][32:0]}) * $signed({1'b0, cfg.fy});
		pfh_y_s4 <= $signed(p_s3[1][PW-1:33]) * $signed({1'b0, cfg.fy});
		zcl_x_s4 <= $signed({1'b0, p_s3[2][32:0]}) * cfg.px;
		zch_x_s4 <= $signed(p_s3[2][PW-1:33]) * cfg.px;
		zcl_y_s4 <= $signed({1'b0, p_s3[2][32:0]}) * cfg.py;
		zch_y_s4 <= $signed(p_s3[2][PW-1:33]) * cfg.py;
		zl_x_s4 <= p_s3[2] * $signed({1'b0, lim_x});
		zl_y_s4 <= p_s3[2] * $signed({1'b0, lim_y});
		z_s4 <= p_s3[2];

		addr_s5 <= addr_s4;
		pf_x_s5 <= (NW'(pfh_x_s4) <<< 33) + NW'(pfl_x_s4);
		pf_y_s5 <= (NW'(pfh_y_s4) <<< 33) + NW'(pfl_y_s4);
		zc_x_s5 <= (NW'(zch_x_s4) <<< 33) + NW'(zcl_x_s4);
		zc_y_s5 <= (NW'(zch_y_s4) <<< 33) + NW'(zcl_y_s4);
		den_s5 <= NW'(z_s4) <<< 16;
		dlim_x_s5 <= NW'(zl_x_s4) <<< 16;
		dlim_y_s5 <= NW'(zl_y_s4) <<< 16;

		addr_s6 <= addr_s5;
		num_x_s6 <= pf_x_s5 + zc_x_s5;
		num_y_s6 <= pf_y_s5 + zc_y_s5;
		den_s6 <= den_s5;
		dlim_x_s6 <= dlim_x_s5;
		dlim_y_s6 <= dlim_y_s5;

		// a negative numerator inside the image truncates to pixel zero
		addr_d[0] <= addr_s6;
		rem_x_d[0] <= num_x_s6[NW-1] ? '0 : num_x_s6;
		rem_y_d[0] <= num_y_s6[NW-1] ? '0 : num_y_s6;
		den_d[0] <= den_s6;
		q_x_d[0] <= '0;
		q_y_d[0] <= '0;
	end

	// restoring divider, one quotient bit per stage, most significant first
	for (genvar i = 0; i < QW; i++) begin : g_div
		localparam int B = QW - 1 - i;
		logic signed [NW-1:0] dx;
		logic signed [NW-1:0] dy;

		assign dx = rem_x_d[i] - (den_d[i] <<< B);
		assign dy = rem_y_d[i] - (den_d[i] <<< B);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_d[i+1] <= '0;
			end else begin
				ctl_d[i+1] <= ctl_d[i];
			end
		end

		always_ff @(posedge clk) begin
			addr_d[i+1] <= addr_d[i];
			den_d[i+1] <= den_d[i];
			rem_x_d[i+1] <= dx[NW-1] ? rem_x_d[i] : dx;
			rem_y_d[i+1] <= dy[NW-1] ? rem_y_d[i] : dy;
			q_x_d[i+1] <= q_x_d[i] | (QW'(!dx[NW-1]) << B);
			q_y_d[i+1] <= q_y_d[i] | (QW'(!dy[NW-1]) << B);
		end
	end

	// mask access: writes and reads share the stage so order is kept
	always_ff @(posedge clk) begin
		addr_sa <= ctl_d[QW].is_mask ? addr_d[QW] : mask_addr(q_y_d[QW], q_x_d[QW]);
		if (ctl_sa.vld && ctl_sa.is_mask) begin
			mask_mem[addr_sa] <= ctl_sa.pix_on;
		end
		mask_bit_sm <= mask_mem[addr_sa];
	end

	// label update
	always_comb begin
		res_push = ctl_sm.vld && !ctl_sm.is_mask;
		res_label = ctl_sm.label;
		res_outcome = ctl_sm.outcome;
		if (!ctl_sm.done) begin
			if (!mask_bit_sm) begin
				res_label = LBL_CARVED;
				res_outcome = OUT_CARVED;
			end else if (ctl_sm.label == LBL_UNSEEN) begin
				res_label = LBL_SEEN;
				res_outcome = OUT_FIRST;
			end else begin
				res_outcome = OUT_AGAIN;
			end
		end
	end

endmodule

// File: rtl/core/voxel_space_carving_check.sv
// top level of the voxel space carving check: configuration registers and the
// front queue, back pipeline and result queue; depends on vscc_pkg, vscc_front,
// vscc_fifo, vscc_back and voxel_space_carving_check_macros.svh
//
// usage
//  - input words enter through push/full: mode 0 loads a pose coefficient,
//    mode 1 loads a mask pixel, mode 2 checks a voxel against the view
//  - each voxel word gives one result word (label_out, outcome) on the
//    empty/pop side, in input order; load words give none
//  - configuration goes through the apb port while the block is idle
//  - throughput: one word per clock while the result queue has room, set by the
//    projection pipeline, which takes a voxel every cycle unless all places are reserved
//  - a voxel reaches the result queue through the middle queue, the projection stages,
//    the pipelined restoring divider (one pixel bit per stage, 11 stages) and the mask stages
//  - when pop stays low the result queue (32 words) fills, the back part
//    stops taking voxels once all places are spoken for, the front queue
//    fills and full goes high; nothing is dropped
//  - reset clears the pose, the queues and the registers to their defaults;
//    mask pixels must be loaded before voxels read them
module voxel_space_carving_check #(
	parameter int MAX_MASK_WIDTH = vscc_pkg::DEF_MAX_MASK_WIDTH,
	parameter int MAX_MASK_HEIGHT = vscc_pkg::DEF_MAX_MASK_HEIGHT
) (
	input logic clk,
	input logic arst_n,
	// apb configuration port
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// input words
	input logic push,
	output logic full,
	input logic [1:0] mode,
	input logic [3:0] coef_index,
	input logic signed [31:0] coef_value,
	input logic [9:0] pixel_col,
	input logic [9:0] pixel_row,
	input logic pixel_on,
	input logic signed [31:0] center_x,
	input logic signed [31:0] center_y,
	input logic signed [31:0] center_z,
	input logic [1:0] label_in,
	// result words
	output logic empty,
	input logic pop,
	output logic [1:0] label_out,
	output logic [2:0] outcome
);
	import vscc_pkg::*;

	localparam int QIW = $bits(qitem_t);
	localparam int RW = 5;

	// configuration registers
	logic [30:0] focal_x_q;
	logic [30:0] focal_y_q;
	logic signed [31:0] principal_x_q;
	logic signed [31:0] principal_y_q;
	logic [10:0] image_width_q;
	logic [10:0] image_height_q;
	logic cfg_wr;
	logic [2:0] reg_idx;
	cfg_t cfg;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= FOCAL_RESET;
			focal_y_q <= FOCAL_RESET;
			principal_x_q <= '0;
			principal_y_q <= '0;
			image_width_q <= IMAGE_SIZE_RESET;
			image_height_q <= IMAGE_SIZE_RESET;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_FOCAL_X: focal_x_q <= pwdata[30:0];
				REG_FOCAL_Y: focal_y_q <= pwdata[30:0];
				REG_PRINCIPAL_X: principal_x_q <= pwdata;
				REG_PRINCIPAL_Y: principal_y_q <= pwdata;
				REG_IMAGE_WIDTH: image_width_q <= pwdata[10:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_FOCAL_X: prdata = {1'b0, focal_x_q};
			REG_FOCAL_Y: prdata = {1'b0, focal_y_q};
			REG_PRINCIPAL_X: prdata = principal_x_q;
			REG_PRINCIPAL_Y: prdata = principal_y_q;
			REG_IMAGE_WIDTH: prdata = {21'b0, image_width_q};
			REG_IMAGE_HEIGHT: prdata = {21'b0, image_height_q};
			default: prdata = '0;
		endcase
	end

	always_comb begin
		cfg.fx = focal_x_q;
		cfg.fy = focal_y_q;
		cfg.px = principal_x_q;
		cfg.py = principal_y_q;
		cfg.width = image_width_q;
		cfg.height = image_height_q;
	end

	// front: classify and queue
	logic mid_push;
	logic mid_full;
	logic mid_pop;
	logic mid_empty;
	qitem_t mid_din;
	logic [QIW-1:0] mid_dout;

	vscc_front #(
		.MAX_MASK_WIDTH(MAX_MASK_WIDTH),
		.MAX_MASK_HEIGHT(MAX_MASK_HEIGHT)
	) u_front (
		.push(push),
		.full(full),
		.mode(mode),
		.coef_index(coef_index),
		.coef_value(coef_value),
		.pixel_col(pixel_col),
		.pixel_row(pixel_row),
		.pixel_on(pixel_on),
		.center_x(center_x),
		.center_y(center_y),
		.center_z(center_z),
		.label_in(label_in),
		.q_full(mid_full),
		.q_push(mid_push),
		.q_item(mid_din)
	);

	// short queue that decouples the front from the back
	vscc_fifo #(
		.WIDTH(QIW),
		.DEPTH(MID_DEPTH)
	) u_mid_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(mid_push),
		.din(mid_din),
		.full(mid_full),
		.pop(mid_pop),
		.dout(mid_dout),
		.empty(mid_empty)
	);

	// back: pose store, projection, mask lookup
	logic res_push;
	logic res_full;
	logic res_taken;
	logic [1:0] res_label;
	outcome_t res_outcome;
	logic [RW-1:0] res_dout;

	assign res_taken = pop && !empty;

	vscc_back #(
		.MAX_MASK_WIDTH(MAX_MASK_WIDTH),
		.MAX_MASK_HEIGHT(MAX_MASK_HEIGHT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.item_valid(!mid_empty),
		.item(qitem_t'(mid_dout)),
		.item_pop(mid_pop),
		.res_taken(res_taken),
		.res_push(res_push),
		.res_label(res_label),
		.res_outcome(res_outcome)
	);

	// result queue; the back part reserves a place before each voxel goes in
	vscc_fifo #(
		.WIDTH(RW),
		.DEPTH(OUT_DEPTH)
	) u_res_q (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_push),
		.din({res_label, res_outcome}),
		.full(res_full),
		.pop(pop),
		.dout(res_dout),
		.empty(empty)
	);

	assign label_out = res_dout[4:3];
	assign outcome = res_dout[2:0];

	`include "voxel_space_carving_check_macros.svh"

	`VSCC_ASSERT_IMPLY(a_res_no_overflow, res_push, !res_full)
	`VSCC_ASSERT_IMPLY(a_mid_no_overflow, mid_push, !mid_full)
	`VSCC_ASSERT_IMPLY(a_mid_pop_valid, mid_pop, !mid_empty)
	`VSCC_ASSERT_NEXT(a_empty_holds, empty && !res_push, empty)

endmodule

// File: verif/voxel_space_carving_check_test.sv
// self-checking testbench of the voxel space carving check: a queue-fed driver, a result
// monitor and an in-order prediction of label_out and outcome for every voxel word
// depends on vscc_pkg and voxel_space_carving_check
module voxel_space_carving_check_test;
	timeunit 1ns;
	timeprecision 1ps;
	import vscc_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int MASK_ROW = 1024;

	// one input word plus what it should produce
	typedef struct {
		logic [1:0] mode;
		logic [3:0] idx;
		logic signed [31:0] value;
		logic [9:0] col;
		logic [9:0] row;
		logic on;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [1:0] lbl;
		bit has_res;
		logic [1:0] want_lbl;
		outcome_t want_oc;
	} carve_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	logic [1:0] mode = '0;
	logic [3:0] coef_index = '0;
	logic signed [31:0] coef_value = '0;
	logic [9:0] pixel_col = '0, pixel_row = '0;
	logic pixel_on = 1'b0;
	logic signed [31:0] center_x = '0, center_y = '0, center_z = '0;
	logic [1:0] label_in = '0;
	logic empty;
	logic pop = 1'b0;
	logic [1:0] label_out;
	logic [2:0] outcome;

	// words waiting to be pushed, and verdicts waiting to come out
	carve_word_t pending_words[$];
	carve_word_t verdicts_due[$];

	// shadow of the view: pose, mask pixels written so far, registers
	logic signed [31:0] pose_m[12];
	bit mask_m[int];
	logic [30:0] fx_m, fy_m;
	logic signed [31:0] cx_m, cy_m;
	logic [10:0] w_m, h_m;

	int errors = 0;
	int cycles = 0;
	int oc_seen[6];
	int pop_pct = 100;
	bit bursty = 1'b0;
	int gap_left = 0, burst_left = 0, run_left = 0;
	bit pop_state = 1'b1;

	voxel_space_carving_check u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready),
		.push(push), .full(full), .mode(mode), .coef_index(coef_index),
		.coef_value(coef_value), .pixel_col(pixel_col), .pixel_row(pixel_row),
		.pixel_on(pixel_on), .center_x(center_x), .center_y(center_y),
		.center_z(center_z), .label_in(label_in),
		.empty(empty), .pop(pop), .label_out(label_out), .outcome(outcome)
	);

	always #6 clk = ~clk;

	function automatic carve_word_t blank_word(input logic [1:0] m);
		carve_word_t w;
		w.mode = m;
		w.idx = 4'($urandom_range(0, 15));
		w.value = $urandom;
		w.col = 10'($urandom_range(0, 1023));
		w.row = 10'($urandom_range(0, 1023));
		w.on = 1'($urandom_range(0, 1));
		w.cx = $urandom;
		w.cy = $urandom;
		w.cz = $urandom;
		w.lbl = 2'($urandom_range(0, 3));
		w.has_res = 1'b0;
		w.want_lbl = LBL_UNSEEN;
		w.want_oc = OUT_ALREADY;
		return w;
	endfunction

	// camera coordinate of pose row k at 2^-46 resolution
	function automatic logic signed [127:0] cam_axis(input int k,
			input logic signed [31:0] x, y, z);
		logic signed [127:0] acc, a, b;
		logic signed [31:0] c3[3];
		c3[0] = x;
		c3[1] = y;
		c3[2] = z;
		acc = pose_m[9 + k];
		acc = acc <<< 30;
		for (int j = 0; j < 3; j++) begin
			a = pose_m[3 * k + j];
			b = c3[j];
			acc = acc + a * b;
		end
		return acc;
	endfunction

	// truncated pixel p*f/z + c, valid only when it lands in [0, lim)
	function automatic bit to_pixel(input logic signed [127:0] p, z, input logic [30:0] f,
			input logic signed [31:0] c, input int lim, output int pix);
		logic signed [127:0] fw, cw, num, den, lw, q;
		fw = {97'b0, f};
		cw = c;
		lw = lim;
		num = p * fw + z * cw;
		den = z <<< 16;
		pix = 0;
		if (lim == 0) return 1'b0;
		if (num + den <= 0) return 1'b0;
		if (den * lw - num <= 0) return 1'b0;
		if (num >= 0) begin
			q = num / den;
			pix = int'(q);
		end
		return 1'b1;
	endfunction

	task automatic queue_word(input carve_word_t w);
		pending_words.push_back(w);
	endtask

	task automatic add_pose(input logic [3:0] idx, input logic signed [31:0] v);
		carve_word_t w;
		w = blank_word(MODE_POSE);
		w.idx = idx;
		w.value = v;
		if (idx < POSE_SLOTS) pose_m[idx] = v;
		queue_word(w);
	endtask

	task automatic add_mask(input int c, r, input bit on);
		carve_word_t w;
		w = blank_word(MODE_MASK);
		w.col = 10'(c);
		w.row = 10'(r);
		w.on = on;
		mask_m[r * MASK_ROW + c] = on;
		queue_word(w);
	endtask

	// predicts the verdict; a pixel never written gets a mask load first
	task automatic add_voxel(input logic signed [31:0] x, y, z, input logic [1:0] lbl);
		carve_word_t w;
		logic signed [127:0] ex, ey, ez;
		logic [1:0] l;
		int col, row, wl, hl, key;
		w = blank_word(MODE_VOXEL);
		w.cx = x;
		w.cy = y;
		w.cz = z;
		w.lbl = lbl;
		w.has_res = 1'b1;
		l = (lbl == LBL_SPARE) ? LBL_SEEN : lbl;
		wl = (w_m < DEF_MAX_MASK_WIDTH) ? int'(w_m) : DEF_MAX_MASK_WIDTH;
		hl = (h_m < DEF_MAX_MASK_HEIGHT) ? int'(h_m) : DEF_MAX_MASK_HEIGHT;
		if (l == LBL_CARVED) begin
			w.want_oc = OUT_ALREADY;
		end else begin
			ex = cam_axis(0, x, y, z);
			ey = cam_axis(1, x, y, z);
			ez = cam_axis(2, x, y, z);
			if (ez <= 0) begin
				w.want_oc = OUT_BEHIND;
			end else if (!to_pixel(ex, ez, fx_m, cx_m, wl, col) ||
					!to_pixel(ey, ez, fy_m, cy_m, hl, row)) begin
				w.want_oc = OUT_OUTSIDE;
			end else begin
				key = row * MASK_ROW + col;
				if (!mask_m.exists(key)) add_mask(col, row, $urandom_range(0, 1));
				if (!mask_m[key]) begin
					l = LBL_CARVED;
					w.want_oc = OUT_CARVED;
				end else if (l == LBL_UNSEEN) begin
					l = LBL_SEEN;
					w.want_oc = OUT_FIRST;
				end else begin
					w.want_oc = OUT_AGAIN;
				end
			end
		end
		w.want_lbl = l;
		queue_word(w);
	endtask

	// a plausible coefficient: near identity rotation, camera a few units back
	function automatic logic signed [31:0] sane_coef(input int idx);
		int noise;
		noise = int'($urandom_range(0, 1 << 25)) - (1 << 24);
		if (idx == 0 || idx == 4 || idx == 8) return (32'sd1 <<< 30) + noise;
		if (idx < 9) return noise;
		if (idx == 11) return $urandom_range(3 << 16, 6 << 16);
		return noise >>> 7;
	endfunction

	task automatic write_reg(input logic [2:0] r, input logic [31:0] v);
		case (r)
			REG_FOCAL_X: fx_m = v[30:0];
			REG_FOCAL_Y: fy_m = v[30:0];
			REG_PRINCIPAL_X: cx_m = v;
			REG_PRINCIPAL_Y: cy_m = v;
			REG_IMAGE_WIDTH: w_m = v[10:0];
			REG_IMAGE_HEIGHT: h_m = v[10:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {r, 2'b00};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// all words pushed, all verdicts back, then let the pipe settle
	task automatic drain();
		wait (pending_words.size() == 0 && verdicts_due.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic run_view(input int n, input int pct, input bit gaps);
		int r;
		logic signed [31:0] x, y, z;
		pop_pct = pct;
		bursty = gaps;
		for (int i = 0; i < 12; i++) add_pose(i, sane_coef(i));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 4) begin
				r = $urandom_range(0, 15);
				add_pose(r, ($urandom_range(0, 4) == 0) ? $urandom : sane_coef(r));
			end else if (r < 16) begin
				add_mask($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1));
			end else if (r < 19) begin
				queue_word(blank_word(MODE_UNUSED));
			end else begin
				if ($urandom_range(0, 9) < 7) begin
					// centers within a couple of units of the origin
					x = int'($urandom_range(0, 262143)) - 131072;
					y = int'($urandom_range(0, 262143)) - 131072;
					z = int'($urandom_range(0, 262143)) - 131072;
				end else begin
					x = $urandom;
					y = $urandom;
					z = $urandom;
				end
				add_voxel(x, y, z, $urandom_range(0, 3));
			end
		end
		drain();
	endtask

	// driver: presents the head of the queue, in bursts when bursty is set
	always @(negedge clk) begin
		if (!arst_n || pending_words.size() == 0) begin
			push <= 1'b0;
		end else if (gap_left > 0) begin
			gap_left = gap_left - 1;
			push <= 1'b0;
		end else if (bursty && burst_left == 0) begin
			gap_left = $urandom_range(0, 7);
			burst_left = $urandom_range(1, 12);
			push <= 1'b0;
		end else begin
			if (burst_left > 0) burst_left = burst_left - 1;
			push <= 1'b1;
			mode <= pending_words[0].mode;
			coef_index <= pending_words[0].idx;
			coef_value <= pending_words[0].value;
			pixel_col <= pending_words[0].col;
			pixel_row <= pending_words[0].row;
			pixel_on <= pending_words[0].on;
			center_x <= pending_words[0].cx;
			center_y <= pending_words[0].cy;
			center_z <= pending_words[0].cz;
			label_in <= pending_words[0].lbl;
		end
	end

	// receiver: pop held high or low for random runs
	always @(negedge clk) begin
		if (run_left == 0) begin
			pop_state = ($urandom_range(0, 99) < pop_pct);
			run_left = $urandom_range(1, 10);
		end
		run_left = run_left - 1;
		pop <= pop_state;
	end

	// monitor: accepted words and verdicts, plus the watchdog
	always @(posedge clk) begin
		carve_word_t w;
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d words and %0d verdicts outstanding", $realtime,
				pending_words.size(), verdicts_due.size());
			$display("voxel_space_carving_check_test: errors");
			$finish;
		end
		if (arst_n) begin
			if (push && !full && pending_words.size() > 0) begin
				w = pending_words.pop_front();
				if (w.has_res) verdicts_due.push_back(w);
			end
			if (pop && !empty) begin
				if (verdicts_due.size() == 0) begin
					errors++;
					$display("%0t unexpected word: label_out %0d outcome %0d", $realtime,
						label_out, outcome);
				end else begin
					w = verdicts_due.pop_front();
					if (label_out !== w.want_lbl) begin
						errors++;
						$display("%0t label_out: expected %0d actual %0d", $realtime,
							w.want_lbl, label_out);
					end
					if (outcome !== w.want_oc) begin
						errors++;
						$display("%0t outcome: expected %0d actual %0d", $realtime,
							w.want_oc, outcome);
					end
					if (w.want_oc <= OUT_AGAIN) oc_seen[w.want_oc]++;
				end
			end
		end
	end

	initial begin
		for (int i = 0; i < 12; i++) pose_m[i] = '0;
		fx_m = FOCAL_RESET;
		fy_m = FOCAL_RESET;
		cx_m = '0;
		cy_m = '0;
		w_m = IMAGE_SIZE_RESET;
		h_m = IMAGE_SIZE_RESET;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed pass at reset settings: unit focal length, pixel = x / z
		for (int i = 0; i < 12; i++) add_pose(i, (i % 4 == 0) ? (32'sd1 <<< 30) : 32'sd0);
		add_pose(11, 32'sd4 <<< 16);
		add_pose(12, 32'h7fffffff);              // slot past the pose, ignored
		add_pose(15, 32'h80000000);
		queue_word(blank_word(MODE_UNUSED));     // unused mode
		add_mask(1023, 1023, 1'b1);
		add_mask(0, 0, 1'b0);
		add_mask(3, 0, 1'b0);
		add_mask(5, 1, 1'b1);
		add_voxel(32'sd12 <<< 16, 0, 0, LBL_UNSEEN);        // carved
		add_voxel(32'sd20 <<< 16, 32'sd4 <<< 16, 0, LBL_UNSEEN); // first seen
		add_voxel(32'sd20 <<< 16, 32'sd4 <<< 16, 0, LBL_SEEN);   // seen again
		add_voxel(32'sd20 <<< 16, 32'sd4 <<< 16, 0, LBL_SPARE);  // label three acts as seen
		add_voxel(32'sd20 <<< 16, 32'sd4 <<< 16, 0, LBL_CARVED); // stays carved
		add_voxel(0, 0, -(32'sd4 <<< 16), LBL_UNSEEN);          // zero depth
		add_voxel(0, 0, -(32'sd9 <<< 16), LBL_SEEN);            // behind the camera
		add_voxel(-(32'sd4 <<< 16), 0, 0, LBL_UNSEEN);          // left of the image
		add_voxel(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, LBL_UNSEEN);
		add_voxel(32'h80000000, 32'h80000000, 32'h80000000, LBL_SEEN);
		add_pose(0, 32'h80000000);
		add_pose(2, 32'h7fffffff);
		add_voxel(32'sd1 <<< 16, 32'sd1 <<< 16, 32'sd1 <<< 16, LBL_UNSEEN);
		drain();

		// a realistic camera on the full image, heavy traffic
		write_reg(REG_FOCAL_X, 32'd500 << 16);
		write_reg(REG_FOCAL_Y, 32'd480 << 16);
		write_reg(REG_PRINCIPAL_X, 32'd512 << 16);
		write_reg(REG_PRINCIPAL_Y, 32'd500 << 16);
		run_view(100, 100, 1'b0);
		run_view(80, 15, 1'b1);

		// small image with a short lens, random stalls on both sides
		write_reg(REG_IMAGE_WIDTH, 32'd16);
		write_reg(REG_IMAGE_HEIGHT, 32'd8);
		write_reg(REG_FOCAL_X, 32'd9 << 16);
		write_reg(REG_FOCAL_Y, 32'd5 << 16);
		write_reg(REG_PRINCIPAL_X, 32'd8 << 16);
		write_reg(REG_PRINCIPAL_Y, 32'h0004_8000);
		run_view(100, 60, 1'b1);

		// extremes: largest and zero focal length, principal points at both ends, one pixel
		write_reg(REG_FOCAL_X, 32'h7fffffff);
		write_reg(REG_FOCAL_Y, 32'd0);
		write_reg(REG_PRINCIPAL_X, 32'h80000000);
		write_reg(REG_PRINCIPAL_Y, 32'h7fffffff);
		write_reg(REG_IMAGE_WIDTH, 32'd1);
		write_reg(REG_IMAGE_HEIGHT, 32'd1);
		run_view(40, 80, 1'b1);

		// no width at all: no voxel lands in the image
		write_reg(REG_IMAGE_WIDTH, 32'd0);
		write_reg(REG_IMAGE_HEIGHT, 32'd5);
		run_view(30, 100, 1'b0);

		// sizes past the mask store get clamped
		write_reg(REG_IMAGE_WIDTH, 32'd2047);
		write_reg(REG_IMAGE_HEIGHT, 32'd1500);
		write_reg(REG_FOCAL_X, 32'd300 << 16);
		write_reg(REG_FOCAL_Y, 32'd300 << 16);
		write_reg(REG_PRINCIPAL_X, 32'd1000 << 16);
		write_reg(REG_PRINCIPAL_Y, 32'd1010 << 16);
		run_view(100, 40, 1'b1);

		if (verdicts_due.size() != 0) begin
			errors++;
			$display("%0t %0d verdicts never arrived", $realtime, verdicts_due.size());
		end
		$display("verdicts by outcome: already %0d, behind %0d, outside %0d, carved %0d",
			oc_seen[0], oc_seen[1], oc_seen[2], oc_seen[3]);
		$display("  first seen %0d, seen again %0d; %0d mismatches", oc_seen[4], oc_seen[5],
			errors);
		if (errors == 0) begin
			$display("voxel_space_carving_check_test: clean");
		end else begin
			$display("voxel_space_carving_check_test: errors");
		end
		$finish;
	end

endmodule
